// ===== hdl/pwl_pkg.sv =====
// Package of types and constants for the piecewise linear table interpolator.
`default_nettype none

package pwl_pkg;

	// Item functions.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_USED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_SPAN   = 1'd1;

	// Reset values of the configuration registers.
	localparam logic [4:0] ENTRIES_USED_RST = 5'd16;
	localparam logic [7:0] ERROR_SPAN_RST   = 8'd43;

	// Limits of the error output.
	localparam logic [23:0] ERR_MIN = 24'd5;
	localparam logic [23:0] ERR_MAX = 24'hFF_FFFF;

	// Shared divider: remainder and numerator widths, double steps per division.
	localparam int unsigned DIV_REM_W   = 20;
	localparam int unsigned DIV_NUM_W   = 34;
	localparam logic [4:0]  SLOPE_STEPS = 5'd13;
	localparam logic [4:0]  ERR_STEPS   = 5'd17;

	typedef struct packed {
		logic               func;
		logic [3:0]         entry_index;
		logic signed [15:0] entry_x;
		logic signed [23:0] entry_y;
		logic signed [15:0] query_x;
		logic [19:0]        error_divisor;
	} item_t;

	typedef struct packed {
		logic signed [23:0] interp_y;
		logic [23:0]        error_out;
	} result_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [23:0] y;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_FETCH,
		S_SDIV,
		S_SLOPE,
		S_MULY,
		S_SUM,
		S_ELOAD,
		S_EDIV,
		S_FIN
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/piecewise_linear_table_interp_top.sv =====
// Top level of the piecewise linear table interpolator.
//
// Items arrive on the item channel (valid/ready). A load item writes one
// breakpoint of the table in the cycle of its transfer and gives no result.
// A query item scans the table from index 1 for the first breakpoint whose
// x is not above the query, one entry per cycle through the table's single
// read port, then runs two divisions on one shared restoring divider (two
// quotient bits per cycle) and two products on one shared multiplier.
// The scan, the two divisions and the two products run one after another,
// and a query holds the input until its result is loaded into the output
// register. Loads can follow back to back.
// item_ready is low while a query is being worked on.
// Results leave through an output register on the result channel; while a
// stalled receiver leaves an earlier result in that register, a finished
// query waits in its last step and no item is taken until the register frees.
// The configuration channel is always ready; writes belong to idle periods.
// Reset sets entries_used to 16 and error_span to 43 and empties the output
// register. The table is not cleared: an entry must be loaded before use.
`default_nettype none

module piecewise_linear_table_interp_top #(
	parameter int unsigned TABLE_DEPTH = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               item_valid,
	output logic                              item_ready,
	input  wire pwl_pkg::item_t               item,
	output logic                              result_valid,
	input  wire                               result_ready,
	output pwl_pkg::result_t                  result,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [pwl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [7:0]                         cfg_data
);

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned REM_W = pwl_pkg::DIV_REM_W;
	localparam int unsigned NUM_W = pwl_pkg::DIV_NUM_W;

	// One restoring division step: shift in the next numerator bit, subtract if it fits.
	function automatic logic [REM_W+NUM_W-1:0] div_step(
		input logic [REM_W+NUM_W-1:0] rn,
		input logic [REM_W-1:0]       d
	);
		logic [REM_W:0]           t;
		logic [REM_W+NUM_W-1:0]   r;
		t = {rn[REM_W+NUM_W-1:NUM_W], rn[NUM_W-1]};
		if (t >= {1'b0, d}) begin
			r = {REM_W'(t - {1'b0, d}), rn[NUM_W-2:0], 1'b1};
		end else begin
			r = {t[REM_W-1:0], rn[NUM_W-2:0], 1'b0};
		end
		return r;
	endfunction

	pwl_pkg::state_t state_q, state_d;

	logic [4:0]          entries_used_q;
	logic [7:0]          error_span_q;

	pwl_pkg::entry_t     mem_q [TABLE_DEPTH];
	pwl_pkg::entry_t     rd_q;
	logic                mem_we;
	logic [IDX_W-1:0]    wr_addr;
	logic [IDX_W-1:0]    rd_addr;

	logic [IDX_W-1:0]    i_q;
	logic [IDX_W-1:0]    last_q;
	logic [IDX_W-1:0]    last_d;
	logic signed [15:0]  qx_q;
	logic [19:0]         div_q;
	logic signed [15:0]  x1_q;
	logic signed [23:0]  y0_q;
	logic signed [23:0]  y1_q;
	logic                neg_q;
	logic                flat_q;
	logic signed [25:0]  slope_q;
	logic signed [42:0]  prod_q;
	logic signed [43:0]  sum_q;
	logic signed [23:0]  y_q;

	logic [REM_W-1:0]    rem_q;
	logic [NUM_W-1:0]    num_q;
	logic [REM_W-1:0]    d_q;
	logic [4:0]          cnt_q;

	logic                result_valid_q;
	pwl_pkg::result_t    result_q;

	logic                item_xfer;
	logic                scan_more;
	logic                div_last;
	logic                result_load;

	logic signed [16:0]  dx;
	logic signed [24:0]  dy;
	logic [16:0]         dx_mag;
	logic [24:0]         dy_mag;
	logic [25:0]         slope_abs;
	logic [24:0]         q_slope;
	logic signed [25:0]  mul_a;
	logic signed [16:0]  mul_b;
	logic signed [42:0]  mul_p;
	logic [REM_W+NUM_W-1:0] div_next;
	logic signed [23:0]  lo_y;
	logic signed [23:0]  hi_y;
	logic signed [23:0]  y_clamped;
	logic [23:0]         err_sat;

	assign item_xfer   = item_valid && item_ready;
	assign cfg_ready   = 1'b1;
	assign scan_more   = (i_q < last_q) && (qx_q < rd_q.x);
	assign div_last    = (cnt_q == 5'd1);
	assign result_load = (state_q == pwl_pkg::S_FIN) && (!result_valid_q || result_ready);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_used_q <= pwl_pkg::ENTRIES_USED_RST;
			error_span_q   <= pwl_pkg::ERROR_SPAN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pwl_pkg::REG_ENTRIES_USED: entries_used_q <= cfg_data[4:0];
				pwl_pkg::REG_ERROR_SPAN:   error_span_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Last index in use: entries_used clamped to the range 2 to TABLE_DEPTH.
	always_comb begin
		priority if (32'(entries_used_q) > TABLE_DEPTH) begin
			last_d = IDX_W'(TABLE_DEPTH - 1);
		end else if (entries_used_q < 5'd2) begin
			last_d = IDX_W'(1);
		end else begin
			last_d = IDX_W'(entries_used_q - 5'd1);
		end
	end

	// Breakpoint table: one write port, one registered read port.
	assign wr_addr = IDX_W'(item.entry_index);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= '{x: item.entry_x, y: item.entry_y};
		end
		rd_q <= mem_q[rd_addr];
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, handshake and table port control.
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		mem_we     = 1'b0;
		rd_addr    = IDX_W'(i_q + IDX_W'(1));
		unique case (state_q)
			pwl_pkg::S_IDLE: begin
				item_ready = 1'b1;
				rd_addr    = IDX_W'(1);
				if (item_xfer) begin
					if (item.func == pwl_pkg::FUNC_QUERY) begin
						state_d = pwl_pkg::S_SCAN;
					end else begin
						mem_we = (32'(item.entry_index) < TABLE_DEPTH);
					end
				end
			end
			pwl_pkg::S_SCAN: begin
				if (!scan_more) begin
					rd_addr = IDX_W'(i_q - IDX_W'(1));
					state_d = pwl_pkg::S_FETCH;
				end
			end
			pwl_pkg::S_FETCH: state_d = pwl_pkg::S_SDIV;
			pwl_pkg::S_SDIV:  if (div_last) state_d = pwl_pkg::S_SLOPE;
			pwl_pkg::S_SLOPE: state_d = pwl_pkg::S_MULY;
			pwl_pkg::S_MULY:  state_d = pwl_pkg::S_SUM;
			pwl_pkg::S_SUM:   state_d = pwl_pkg::S_ELOAD;
			pwl_pkg::S_ELOAD: state_d = pwl_pkg::S_EDIV;
			pwl_pkg::S_EDIV:  if (div_last) state_d = pwl_pkg::S_FIN;
			pwl_pkg::S_FIN:   if (result_load) state_d = pwl_pkg::S_IDLE;
			default:          state_d = pwl_pkg::S_IDLE;
		endcase
	end

	// Segment differences and their magnitudes.
	assign dx     = 17'(rd_q.x) - 17'(x1_q);
	assign dy     = 25'(rd_q.y) - 25'(y1_q);
	assign dx_mag = dx[16] ? 17'(-dx) : 17'(dx);
	assign dy_mag = dy[24] ? 25'(-dy) : 25'(dy);

	// Slope quotient and its magnitude.
	assign q_slope   = num_q[24:0];
	assign slope_abs = slope_q[25] ? 26'(-slope_q) : 26'(slope_q);

	// Shared multiplier: the y product first, then slope magnitude times span.
	always_comb begin
		if (state_q == pwl_pkg::S_MULY) begin
			mul_a = slope_q;
			mul_b = 17'(qx_q) - 17'(x1_q);
		end else begin
			mul_a = $signed({1'b0, slope_abs[24:0]});
			mul_b = $signed({9'b0, error_span_q});
		end
	end
	assign mul_p = 43'(mul_a) * 43'(mul_b);

	// Two division steps per cycle.
	assign div_next = div_step(div_step({rem_q, num_q}, d_q), d_q);

	// Clamp to the segment's two y values.
	assign lo_y = (y0_q < y1_q) ? y0_q : y1_q;
	assign hi_y = (y0_q < y1_q) ? y1_q : y0_q;

	always_comb begin
		priority if (sum_q < 44'(lo_y)) begin
			y_clamped = lo_y;
		end else if (sum_q > 44'(hi_y)) begin
			y_clamped = hi_y;
		end else begin
			y_clamped = sum_q[23:0];
		end
	end

	// Error span limits.
	always_comb begin
		priority if (num_q < NUM_W'(pwl_pkg::ERR_MIN)) begin
			err_sat = pwl_pkg::ERR_MIN;
		end else if (num_q > NUM_W'(pwl_pkg::ERR_MAX)) begin
			err_sat = pwl_pkg::ERR_MAX;
		end else begin
			err_sat = num_q[23:0];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			pwl_pkg::S_IDLE: begin
				i_q    <= IDX_W'(1);
				last_q <= last_d;
				qx_q   <= item.query_x;
				div_q  <= (item.error_divisor == 20'd0) ? 20'd1 : item.error_divisor;
			end
			pwl_pkg::S_SCAN: begin
				if (scan_more) begin
					i_q <= IDX_W'(i_q + IDX_W'(1));
				end else begin
					x1_q <= rd_q.x;
					y1_q <= rd_q.y;
				end
			end
			pwl_pkg::S_FETCH: begin
				y0_q   <= rd_q.y;
				neg_q  <= dx[16] ^ dy[24];
				flat_q <= (dx == 17'sd0);
				rem_q  <= '0;
				num_q  <= {1'b0, dy_mag, 8'b0};
				d_q    <= REM_W'(dx_mag);
				cnt_q  <= pwl_pkg::SLOPE_STEPS;
			end
			pwl_pkg::S_SDIV, pwl_pkg::S_EDIV: begin
				{rem_q, num_q} <= div_next;
				cnt_q          <= cnt_q - 5'd1;
			end
			pwl_pkg::S_SLOPE: begin
				if (flat_q) begin
					slope_q <= '0;
				end else if (neg_q) begin
					slope_q <= -$signed({1'b0, q_slope});
				end else begin
					slope_q <= $signed({1'b0, q_slope});
				end
			end
			pwl_pkg::S_MULY: begin
				prod_q <= mul_p;
			end
			pwl_pkg::S_SUM: begin
				sum_q  <= 44'(y1_q) + 44'(prod_q);
				prod_q <= mul_p;
			end
			pwl_pkg::S_ELOAD: begin
				y_q   <= y_clamped;
				rem_q <= '0;
				num_q <= {1'b0, prod_q[32:0]};
				d_q   <= div_q;
				cnt_q <= pwl_pkg::ERR_STEPS;
			end
			pwl_pkg::S_FIN: ;
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (result_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			result_q.interp_y  <= y_q;
			result_q.error_out <= err_sat;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	// The scan index stays within the entries in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pwl_pkg::S_SCAN |-> (i_q != '0) && (i_q <= last_q))
		else $error("scan index outside the table in use");

	// A query transfer starts the scan in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer && item.func == pwl_pkg::FUNC_QUERY |=> state_q == pwl_pkg::S_SCAN)
		else $error("query transfer did not start the scan");

	// After a division the remainder is below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pwl_pkg::S_SLOPE && !flat_q) || state_q == pwl_pkg::S_FIN
		|-> rem_q < d_q)
		else $error("divider remainder not below divisor");

	// The interpolated y lies between the segment's end values.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pwl_pkg::S_FIN |-> (y_q >= lo_y) && (y_q <= hi_y))
		else $error("interpolated y outside segment");

	// A new result always carries an error span of at least the minimum.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_load |=> result_valid && result.error_out >= pwl_pkg::ERR_MIN)
		else $error("error span below minimum");
`endif

endmodule

`default_nettype wire
